// ===== hw/rtl/ats_pkg.sv =====
// Shared types and widths for the assembly token scanner.
`timescale 1ns / 1ps

package ats_pkg;

    localparam int KIND_W      = 6;
    localparam int LINE_W      = 32;
    localparam int OFFSET_BITS = 32;
    localparam int SPAN_BITS   = 16;
    localparam int OUT_TDATA_W = ((KIND_W + LINE_W + OFFSET_BITS + SPAN_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (KIND_W + LINE_W + OFFSET_BITS + SPAN_BITS);

    // Token queue: one entry holds all tokens caused by one input byte
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [LINE_W-1:0]      line;
        logic [OFFSET_BITS-1:0] start;
        logic [SPAN_BITS-1:0]   span;
    } tok_t;

    typedef struct packed {
        tok_t t0;
        tok_t t1;
        logic two;
    } grp_t;

endpackage

// ===== hw/rtl/assembly_token_scanner.sv =====
// Top level of the assembly token scanner: stream ports around front, queue and back.
// A token is offered on the master side once it has passed the queue memory and then the output group register.
// Throughput: one source byte per cycle unless the queue is full; a byte that closes one token
//   and emits another needs two output transfers, absorbed by a four-group queue between scanner and output.
// The output stage sets the sustained rate: one token transfer per cycle while m_tready is high.
// Reset (rst_n low, asynchronous): scanner idle, offset 0, line 1, queue and output empty.
`timescale 1ns / 1ps

module assembly_token_scanner (
    input  logic                               clk,
    input  logic                               rst_n,
    // Source byte stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // [7:0] ch
    input  logic                               s_tuser,  // [0] end_of_input
    // Token descriptor stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ats_pkg::OUT_TDATA_W-1:0]    m_tdata,  // kind, line, start, span, pad
    output logic                               m_tlast   // last token caused by one byte
);

    // Scanner to queue
    logic           push;
    ats_pkg::grp_t  wr_grp;

    // Queue to output stage
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    ats_pkg::grp_t  rd_grp;

    ats_pkg::tok_t  out_tok;

    // Front: classify each byte, track the pending token, line and offset
    ats_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .ch       (s_tdata),
        .eoi      (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .grp      (wr_grp)
    );

    // Queue: hold up to four groups of one or two tokens each
    ats_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_grp (wr_grp),
        .pop    (q_pop),
        .rd_grp (rd_grp),
        .full   (q_full),
        .empty  (q_empty)
    );

    // Back: present each token of a group as its own transfer, tlast on the final one
    ats_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_grp     (rd_grp),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok),
        .out_last  (m_tlast)
    );

    // Pack token fields, kind in the lowest bits
    assign m_tdata = {{ats_pkg::OUT_PAD_W{1'b0}}, out_tok.span, out_tok.start,
                      out_tok.line, out_tok.kind};

endmodule

// ===== hw/rtl/ats_front.sv =====
// Scanner front end: classifies each source byte and builds token groups.
`timescale 1ns / 1ps

module ats_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       ch,
    input  logic             eoi,
    input  logic             q_full,
    output logic             push,
    output ats_pkg::grp_t    grp
);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_IDENT   = 4'd1;
    localparam logic [3:0] M_DEC     = 4'd2;
    localparam logic [3:0] M_HEX     = 4'd3;
    localparam logic [3:0] M_BIN     = 4'd4;
    localparam logic [3:0] M_PCT     = 4'd5;
    localparam logic [3:0] M_QUOTE   = 4'd6;
    localparam logic [3:0] M_STR     = 4'd7;
    localparam logic [3:0] M_COMMENT = 4'd8;
    localparam logic [3:0] M_GT      = 4'd9;
    localparam logic [3:0] M_GTGT    = 4'd10;
    localparam logic [3:0] M_LT      = 4'd11;
    localparam logic [3:0] M_AMP     = 4'd12;
    localparam logic [3:0] M_BAR     = 4'd13;

    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_EOL     = 6'd1;
    localparam logic [5:0] K_IDENT   = 6'd2;
    localparam logic [5:0] K_NUMBER  = 6'd3;
    localparam logic [5:0] K_STRING  = 6'd4;
    localparam logic [5:0] K_DOT     = 6'd5;
    localparam logic [5:0] K_COMMA   = 6'd6;
    localparam logic [5:0] K_COLON   = 6'd7;
    localparam logic [5:0] K_HASH    = 6'd8;
    localparam logic [5:0] K_AT      = 6'd9;
    localparam logic [5:0] K_LPAREN  = 6'd10;
    localparam logic [5:0] K_RPAREN  = 6'd11;
    localparam logic [5:0] K_PLUS    = 6'd12;
    localparam logic [5:0] K_MINUS   = 6'd13;
    localparam logic [5:0] K_TILDE   = 6'd14;
    localparam logic [5:0] K_GT      = 6'd15;
    localparam logic [5:0] K_GE      = 6'd16;
    localparam logic [5:0] K_SHR     = 6'd17;
    localparam logic [5:0] K_USHR    = 6'd18;
    localparam logic [5:0] K_LT      = 6'd19;
    localparam logic [5:0] K_LE      = 6'd20;
    localparam logic [5:0] K_SHL     = 6'd21;
    localparam logic [5:0] K_NE      = 6'd22;
    localparam logic [5:0] K_STAR    = 6'd23;
    localparam logic [5:0] K_SLASH   = 6'd24;
    localparam logic [5:0] K_MOD     = 6'd25;
    localparam logic [5:0] K_SAND    = 6'd26;
    localparam logic [5:0] K_AND     = 6'd27;
    localparam logic [5:0] K_SOR     = 6'd28;
    localparam logic [5:0] K_OR      = 6'd29;
    localparam logic [5:0] K_CARET   = 6'd30;
    localparam logic [5:0] K_EQ      = 6'd31;
    localparam logic [5:0] K_BANG    = 6'd32;
    localparam logic [5:0] K_TICK    = 6'd33;
    localparam logic [5:0] K_INVALID = 6'd34;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_TICK   = 8'h60;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    localparam logic [ats_pkg::SPAN_BITS-1:0] SPAN_MAX = '1;

    logic [3:0]                      mode_reg,  mode_next;
    logic [ats_pkg::KIND_W-1:0]      kind_reg,  kind_next;
    logic [ats_pkg::OFFSET_BITS-1:0] start_reg, start_next;
    logic [ats_pkg::SPAN_BITS-1:0]   span_reg,  span_next;
    logic [ats_pkg::OFFSET_BITS-1:0] off_reg,   off_next;
    logic [ats_pkg::LINE_W-1:0]      line_reg,  line_next;
    logic [ats_pkg::LINE_W-1:0]      sline_reg, sline_next;

    logic [7:0]                      c;
    logic                            is_dig, is_alpha, is_hex, is_bin;
    logic [ats_pkg::SPAN_BITS-1:0]   grown;
    logic                            taken, fin, cls;
    logic [ats_pkg::KIND_W-1:0]      fin_kind;
    logic                            a_valid, b_valid;
    ats_pkg::tok_t                   tok_a, tok_b;
    logic                            accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        c        = eoi ? CH_NUL : ch;
        is_dig   = (c >= CH_ZERO) && (c <= CH_NINE);
        is_alpha = ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
        is_hex   = is_dig || ((c >= CH_LO_A) && (c <= CH_LO_F))
                   || ((c >= CH_UP_A) && (c <= CH_UP_F));
        is_bin   = (c == CH_ZERO) || (c == CH_ONE);
        grown    = (span_reg == SPAN_MAX) ? span_reg : span_reg + 1'b1;

        mode_next  = mode_reg;
        kind_next  = kind_reg;
        start_next = start_reg;
        span_next  = span_reg;
        sline_next = sline_reg;
        off_next   = off_reg;
        line_next  = line_reg;
        taken      = 1'b0;
        fin        = 1'b0;
        fin_kind   = kind_reg;

        // Try to extend the pending token
        case (mode_reg)
            M_IDENT:
            begin
                if (is_alpha || is_dig || (c == CH_UNDER))
                begin
                    taken     = 1'b1;
                    span_next = grown;
                end
            end
            M_DEC:
            begin
                if (is_dig)
                begin
                    taken     = 1'b1;
                    span_next = grown;
                end
            end
            M_HEX:
            begin
                if (is_hex)
                begin
                    taken     = 1'b1;
                    span_next = grown;
                    kind_next = K_NUMBER;
                end
            end
            M_PCT:
            begin
                if (is_bin)
                begin
                    taken     = 1'b1;
                    span_next = grown;
                    mode_next = M_BIN;
                    kind_next = K_NUMBER;
                end
            end
            M_BIN:
            begin
                if (is_bin)
                begin
                    taken     = 1'b1;
                    span_next = grown;
                end
            end
            M_QUOTE:
            begin
                if (c == CH_SQUOTE)
                begin
                    taken    = 1'b1;
                    fin      = 1'b1;
                    // a quote pair needs at least one character between
                    fin_kind = (span_reg >= 2) ? K_NUMBER : K_INVALID;
                end
                else if ((c != CH_LF) && (c != CH_NUL))
                begin
                    taken     = 1'b1;
                    span_next = grown;
                end
            end
            M_STR:
            begin
                if (c == CH_DQUOTE)
                begin
                    taken    = 1'b1;
                    fin      = 1'b1;
                    fin_kind = K_STRING;
                end
                else if ((c != CH_LF) && (c != CH_NUL))
                begin
                    taken     = 1'b1;
                    span_next = grown;
                end
            end
            M_COMMENT:
            begin
                if (c == CH_LF)
                begin
                    taken    = 1'b1;
                    fin      = 1'b1;
                    fin_kind = K_EOL;
                end
                else if (c != CH_NUL)
                begin
                    taken     = 1'b1;
                    span_next = grown;
                end
            end
            M_GT:
            begin
                if (c == CH_EQ)
                begin
                    taken    = 1'b1;
                    fin      = 1'b1;
                    fin_kind = K_GE;
                end
                else if (c == CH_GT)
                begin
                    taken     = 1'b1;
                    span_next = grown;
                    mode_next = M_GTGT;
                    kind_next = K_SHR;
                end
            end
            M_GTGT:
            begin
                if (c == CH_GT)
                begin
                    taken    = 1'b1;
                    fin      = 1'b1;
                    fin_kind = K_USHR;
                end
            end
            M_LT:
            begin
                if (c == CH_EQ)
                begin
                    taken    = 1'b1;
                    fin      = 1'b1;
                    fin_kind = K_LE;
                end
                else if (c == CH_LT)
                begin
                    taken    = 1'b1;
                    fin      = 1'b1;
                    fin_kind = K_SHL;
                end
                else if (c == CH_GT)
                begin
                    taken    = 1'b1;
                    fin      = 1'b1;
                    fin_kind = K_NE;
                end
            end
            M_AMP:
            begin
                if (c == CH_AMP)
                begin
                    taken    = 1'b1;
                    fin      = 1'b1;
                    fin_kind = K_SAND;
                end
            end
            M_BAR:
            begin
                if (c == CH_BAR)
                begin
                    taken    = 1'b1;
                    fin      = 1'b1;
                    fin_kind = K_SOR;
                end
            end
            default:
            begin
                taken = 1'b0;
            end
        endcase

        // Close the pending token when this byte cannot extend it
        cls = (mode_reg != M_IDLE) && !taken;

        tok_a.kind  = fin ? fin_kind : kind_reg;
        tok_a.line  = sline_reg;
        tok_a.start = start_reg;
        tok_a.span  = fin ? grown : span_reg;
        a_valid     = fin || cls;
        if (fin)
        begin
            kind_next = fin_kind;
            span_next = grown;
        end
        if (a_valid)
            mode_next = M_IDLE;

        // Start a new token with this byte
        b_valid     = 1'b0;
        tok_b.kind  = K_INVALID;
        tok_b.line  = line_reg;
        tok_b.start = off_reg;
        tok_b.span  = {{(ats_pkg::SPAN_BITS-1){1'b0}}, 1'b1};
        if (!taken)
        begin
            if (c == CH_NUL)
            begin
                b_valid    = 1'b1;
                tok_b.kind = K_EOF;
                tok_b.span = {{(ats_pkg::SPAN_BITS-1){1'b0}}, !eoi};
            end
            else if (is_alpha || is_dig)
            begin
                mode_next  = is_alpha ? M_IDENT : M_DEC;
                kind_next  = is_alpha ? K_IDENT : K_NUMBER;
                start_next = off_reg;
                sline_next = line_reg;
                span_next  = {{(ats_pkg::SPAN_BITS-1){1'b0}}, 1'b1};
            end
            else
            begin
                case (c)
                    CH_SPACE, CH_TAB, CH_CR: b_valid = 1'b0;
                    CH_LF:
                    begin
                        b_valid    = 1'b1;
                        tok_b.kind = K_EOL;
                    end
                    CH_DOLLAR: begin mode_next = M_HEX;     kind_next = K_INVALID; end
                    CH_PCT:    begin mode_next = M_PCT;     kind_next = K_MOD;     end
                    CH_SQUOTE: begin mode_next = M_QUOTE;   kind_next = K_INVALID; end
                    CH_DQUOTE: begin mode_next = M_STR;     kind_next = K_INVALID; end
                    CH_SEMI:   begin mode_next = M_COMMENT; kind_next = K_EOL;     end
                    CH_GT:     begin mode_next = M_GT;      kind_next = K_GT;      end
                    CH_LT:     begin mode_next = M_LT;      kind_next = K_LT;      end
                    CH_AMP:    begin mode_next = M_AMP;     kind_next = K_AND;     end
                    CH_BAR:    begin mode_next = M_BAR;     kind_next = K_OR;      end
                    CH_DOT:    begin b_valid = 1'b1; tok_b.kind = K_DOT;    end
                    CH_COMMA:  begin b_valid = 1'b1; tok_b.kind = K_COMMA;  end
                    CH_COLON:  begin b_valid = 1'b1; tok_b.kind = K_COLON;  end
                    CH_HASH:   begin b_valid = 1'b1; tok_b.kind = K_HASH;   end
                    CH_AT:     begin b_valid = 1'b1; tok_b.kind = K_AT;     end
                    CH_LPAREN: begin b_valid = 1'b1; tok_b.kind = K_LPAREN; end
                    CH_RPAREN: begin b_valid = 1'b1; tok_b.kind = K_RPAREN; end
                    CH_PLUS:   begin b_valid = 1'b1; tok_b.kind = K_PLUS;   end
                    CH_MINUS:  begin b_valid = 1'b1; tok_b.kind = K_MINUS;  end
                    CH_TILDE:  begin b_valid = 1'b1; tok_b.kind = K_TILDE;  end
                    CH_STAR:   begin b_valid = 1'b1; tok_b.kind = K_STAR;   end
                    CH_SLASH:  begin b_valid = 1'b1; tok_b.kind = K_SLASH;  end
                    CH_CARET:  begin b_valid = 1'b1; tok_b.kind = K_CARET;  end
                    CH_EQ:     begin b_valid = 1'b1; tok_b.kind = K_EQ;     end
                    CH_BANG:   begin b_valid = 1'b1; tok_b.kind = K_BANG;   end
                    CH_TICK:   begin b_valid = 1'b1; tok_b.kind = K_TICK;   end
                    default:   begin b_valid = 1'b1; tok_b.kind = K_INVALID; end
                endcase
                if (!b_valid && (c != CH_SPACE) && (c != CH_TAB) && (c != CH_CR))
                begin
                    start_next = off_reg;
                    sline_next = line_reg;
                    span_next  = {{(ats_pkg::SPAN_BITS-1){1'b0}}, 1'b1};
                end
            end
        end

        // Advance position counters
        if (!eoi)
        begin
            off_next = off_reg + 1'b1;
            if (c == CH_LF)
                line_next = line_reg + 1'b1;
        end

        grp.t0  = a_valid ? tok_a : tok_b;
        grp.t1  = tok_b;
        grp.two = a_valid && b_valid;
        push    = accept && (a_valid || b_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            kind_reg  <= '0;
            start_reg <= '0;
            span_reg  <= '0;
            off_reg   <= '0;
            line_reg  <= {{(ats_pkg::LINE_W-1){1'b0}}, 1'b1};
            sline_reg <= {{(ats_pkg::LINE_W-1){1'b0}}, 1'b1};
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            kind_reg  <= kind_next;
            start_reg <= start_next;
            span_reg  <= span_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
            sline_reg <= sline_next;
        end
    end

    a_pend_span: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != M_IDLE) |-> (span_reg != '0))
        else $error("pending token with zero span");

    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fin) |=> (mode_reg == M_IDLE))
        else $error("scanner not idle after a closing byte");

endmodule

// ===== hw/rtl/ats_queue.sv =====
// Short queue of token groups between the scanner and the output stage.
`timescale 1ns / 1ps

module ats_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ats_pkg::grp_t    wr_grp,
    input  logic             pop,
    output ats_pkg::grp_t    rd_grp,
    output logic             full,
    output logic             empty
);

    ats_pkg::grp_t                 mem [ats_pkg::QDEPTH];
    logic [ats_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [ats_pkg::QCNT_W-1:0]    cnt_reg,    cnt_next;

    assign full   = (cnt_reg == ats_pkg::QCNT_W'(ats_pkg::QDEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_grp = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("token queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("token queue underflow");

endmodule

// ===== hw/rtl/ats_back.sv =====
// Output stage: unpacks token groups into single token transfers.
`timescale 1ns / 1ps

module ats_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  ats_pkg::grp_t    q_grp,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output ats_pkg::tok_t    out_tok,
    output logic             out_last
);

    ats_pkg::grp_t  grp_reg;
    logic           busy_reg;
    logic           sel_reg;
    logic           xfer;

    assign out_valid = busy_reg;
    assign out_tok   = sel_reg ? grp_reg.t1 : grp_reg.t0;
    assign out_last  = sel_reg || !grp_reg.two;
    assign xfer      = busy_reg && out_ready;
    // Load the next group once the current one is gone or leaves now
    assign q_pop     = !q_empty && (!busy_reg || (xfer && out_last));

    always_ff @(posedge clk)
    begin
        if (q_pop)
            grp_reg <= q_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sel_reg  <= 1'b0;
        end
        else if (q_pop)
        begin
            busy_reg <= 1'b1;
            sel_reg  <= 1'b0;
        end
        else if (xfer)
        begin
            busy_reg <= !out_last;
            sel_reg  <= !out_last;
        end
    end

    a_sel_two: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> (busy_reg && grp_reg.two))
        else $error("second token selected from a single-token group");

endmodule
